// ----- sv/dpp_pkg.sv -----
`timescale 1ns / 1ps
// dpp_pkg: shared types, character codes and calendar helpers
// for the month/day/year pattern parser; no dependencies

package dpp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] FIELD_MONTH = 2'd0;
   localparam logic [1:0] FIELD_DAY   = 2'd1;
   localparam logic [1:0] FIELD_YEAR  = 2'd2;

   localparam logic [2:0] LEN_STAR     = 3'd1;
   localparam logic [2:0] LEN_MD       = 3'd2;
   localparam logic [2:0] LEN_ACCUM    = 3'd4;
   localparam logic [2:0] LEN_YEAR     = 3'd4;
   localparam logic [2:0] LEN_SAT      = 3'd5;

   localparam logic [3:0] MONTH_LIMIT = 4'd12;
   localparam logic [4:0] DAY_MAX     = 5'd31;
   localparam logic [3:0] MONTH_FEB   = 4'd2;

   // parse record handed from front to back on the last character
   typedef struct packed {
      logic        syntax_err;
      logic [1:0]  field_num;
      logic [2:0]  field_len;
      logic        all_digits;
      logic        is_star;
      logic [13:0] year;
      logic [6:0]  year_hi;   // first two year digits
      logic [6:0]  year_lo;   // last two year digits
      logic [3:0]  month;
      logic [4:0]  day;
      logic [1:0]  known_mask;
   } dpp_rec_type;

   // leap year from the two digit pairs: century rule when the low pair is zero
   function automatic logic leap_from_pairs(input logic [6:0] hi, input logic [6:0] lo);
      if (lo != 7'd0) begin
         return lo[1:0] == 2'b00;
      end
      return hi[1:0] == 2'b00;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- sv/dpp_req_if.sv -----
`timescale 1ns / 1ps
// dpp_req_if: request channel, one pattern character per request
// no dependencies

interface dpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source(output valid, output char_code, output last_char, input ready);
   modport sink(input valid, input char_code, input last_char, output ready);
endinterface

// ----- sv/dpp_rsp_if.sv -----
`timescale 1ns / 1ps
// dpp_rsp_if: response channel, one parse result per pattern
// no dependencies

interface dpp_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [3:0]  month_value;
   logic [4:0]  day_value;
   logic [13:0] year_value;
   logic        month_known;
   logic        day_known;
   logic        year_known;

   modport source(output valid, output valid_res, output month_value, output day_value,
                  output year_value, output month_known, output day_known,
                  output year_known, input ready);
   modport sink(input valid, input valid_res, input month_value, input day_value,
                input year_value, input month_known, input day_known,
                input year_known, output ready);
endinterface

// ----- sv/dpp_front.sv -----
`timescale 1ns / 1ps
// dpp_front: per-character scanner, field splitting, digit accumulation
// depends on dpp_pkg and dpp_req_if

module dpp_front import dpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   dpp_req_if.sink       req_ch,
   input  logic          q_full,
   output logic          push,
   output dpp_rec_type   push_rec
);

   logic [1:0]  fnum_ff, fnum_in;
   logic [2:0]  flen_ff, flen_in;
   logic        alldig_ff, alldig_in;
   logic        star_ff, star_in;
   logic [13:0] acc_ff, acc_in;
   logic [6:0]  pair_ff, pair_in;
   logic [6:0]  hi_ff, hi_in;
   logic        err_ff, err_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [1:0]  mask_ff, mask_in;

   logic        accept;
   logic        is_digit;
   logic [3:0]  dval;
   logic [6:0]  pair_next;
   logic        close_star, close_known;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && req_ch.ready;

   assign is_digit  = (req_ch.char_code >= CHAR_ZERO) && (req_ch.char_code <= CHAR_NINE);
   assign dval      = 4'(req_ch.char_code - CHAR_ZERO);
   assign pair_next = 7'((pair_ff << 3) + (pair_ff << 1) + 7'(dval));

   assign close_star  = (flen_ff == LEN_STAR) && star_ff;
   assign close_known = (flen_ff == LEN_MD) && alldig_ff;

   always_comb begin
      fnum_in   = fnum_ff;
      flen_in   = flen_ff;
      alldig_in = alldig_ff;
      star_in   = star_ff;
      acc_in    = acc_ff;
      pair_in   = pair_ff;
      hi_in     = hi_ff;
      err_in    = err_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      mask_in   = mask_ff;

      if (req_ch.char_code == CHAR_NUL) begin
         err_in = 1'b1;
      end else if (req_ch.char_code == CHAR_SLASH) begin
         if (fnum_ff == FIELD_YEAR) begin
            err_in = 1'b1;
         end else begin
            if (close_known) begin
               if (fnum_ff == FIELD_MONTH) begin
                  if (acc_ff == 14'd0 || acc_ff > 14'(MONTH_LIMIT)) begin
                     err_in = 1'b1;
                  end else begin
                     month_in   = acc_ff[3:0];
                     mask_in[0] = 1'b1;
                  end
               end else begin
                  if (acc_ff == 14'd0 || acc_ff > 14'(DAY_MAX)) begin
                     err_in = 1'b1;
                  end else begin
                     day_in     = acc_ff[4:0];
                     mask_in[1] = 1'b1;
                  end
               end
            end else if (!close_star) begin
               err_in = 1'b1;
            end
            fnum_in = 2'(fnum_ff + 2'd1);
         end
         flen_in   = 3'd0;
         alldig_in = 1'b1;
         star_in   = 1'b0;
         acc_in    = 14'd0;
      end else begin
         if (flen_ff == 3'd0 && req_ch.char_code == CHAR_STAR) begin
            star_in = 1'b1;
         end
         if (!is_digit) begin
            alldig_in = 1'b0;
         end else if (flen_ff < LEN_ACCUM) begin
            acc_in = 14'((acc_ff << 3) + (acc_ff << 1) + 14'(dval));
            // digit pairs for the leap rule
            if (flen_ff[0]) begin
               pair_in = pair_next;
            end else begin
               pair_in = 7'(dval);
            end
            if (flen_ff == 3'd1) begin
               hi_in = pair_next;
            end
         end
         if (flen_ff < LEN_SAT) begin
            flen_in = 3'(flen_ff + 3'd1);
         end
      end
   end

   assign push = accept && req_ch.last_char;

   always_comb begin
      push_rec.syntax_err = err_in;
      push_rec.field_num  = fnum_in;
      push_rec.field_len  = flen_in;
      push_rec.all_digits = alldig_in;
      push_rec.is_star    = star_in;
      push_rec.year       = acc_in;
      push_rec.year_hi    = hi_in;
      push_rec.year_lo    = pair_in;
      push_rec.month      = month_in;
      push_rec.day        = day_in;
      push_rec.known_mask = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         fnum_ff   <= FIELD_MONTH;
         flen_ff   <= 3'd0;
         alldig_ff <= 1'b1;
         star_ff   <= 1'b0;
         acc_ff    <= 14'd0;
         pair_ff   <= 7'd0;
         hi_ff     <= 7'd0;
         err_ff    <= 1'b0;
         month_ff  <= 4'd0;
         day_ff    <= 5'd0;
         mask_ff   <= 2'd0;
      end else if (accept) begin
         fnum_ff   <= fnum_in;
         flen_ff   <= flen_in;
         alldig_ff <= alldig_in;
         star_ff   <= star_in;
         acc_ff    <= acc_in;
         pair_ff   <= pair_in;
         hi_ff     <= hi_in;
         err_ff    <= err_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         mask_ff   <= mask_in;
      end
   end

endmodule

// ----- sv/dpp_queue.sv -----
`timescale 1ns / 1ps
// dpp_queue: two-entry queue of parse records between front and back
// depends on dpp_pkg

module dpp_queue import dpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  dpp_rec_type   push_rec,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output dpp_rec_type   head
);

   dpp_rec_type ent_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign head    = ent_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      cnt_in  = 2'(cnt_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

// ----- sv/dpp_back.sv -----
`timescale 1ns / 1ps
// dpp_back: final year, leap and day-in-month checks, response register
// depends on dpp_pkg and dpp_rsp_if

module dpp_back import dpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  dpp_rec_type   head,
   output logic          pop,
   dpp_rsp_if.source     rsp_ch
);

   logic        vld_ff, vld_in;
   logic        ok_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [13:0] year_ff;
   logic        mknown_ff, dknown_ff, yknown_ff;

   logic        ystar, yknown, leap, ok;

   assign pop = !q_empty && (!vld_ff || rsp_ch.ready);

   always_comb begin
      ystar  = (head.field_len == LEN_STAR) && head.is_star;
      yknown = (head.field_len == LEN_YEAR) && head.all_digits;
      // wildcard year counts as a leap year
      leap   = yknown ? leap_from_pairs(head.year_hi, head.year_lo) : 1'b1;
      ok     = !head.syntax_err && head.field_num == FIELD_YEAR && (ystar || yknown);
      if (yknown && head.year == 14'd0) begin
         ok = 1'b0;
      end
      if (ok && head.known_mask == 2'b11 && head.day > month_len(head.month, leap)) begin
         ok = 1'b0;
      end
      vld_in = pop ? 1'b1 : (rsp_ch.ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ok_ff     <= ok;
         month_ff  <= ok ? head.month : 4'd0;
         day_ff    <= ok ? head.day : 5'd0;
         year_ff   <= (ok && yknown) ? head.year : 14'd0;
         mknown_ff <= ok && head.known_mask[0];
         dknown_ff <= ok && head.known_mask[1];
         yknown_ff <= ok && yknown;
      end
   end

   assign rsp_ch.valid       = vld_ff;
   assign rsp_ch.valid_res   = ok_ff;
   assign rsp_ch.month_value = month_ff;
   assign rsp_ch.day_value   = day_ff;
   assign rsp_ch.year_value  = year_ff;
   assign rsp_ch.month_known = mknown_ff;
   assign rsp_ch.day_known   = dknown_ff;
   assign rsp_ch.year_known  = yknown_ff;

endmodule

// ----- sv/date_pattern_parser.sv -----
`timescale 1ns / 1ps
// date_pattern_parser: month/day/year pattern parser, one character per request
// response path: the record of the last character is written into a queue entry and then
// into the response register, which raises response valid
// throughput: one character per cycle; the front stalls only when the two-entry record
// queue is full, i.e. one response waits unaccepted and two finished patterns sit behind it
// reset: synchronous, active high; clears the field scanner, queue and response valid
// depends on dpp_pkg, dpp_req_if, dpp_rsp_if, dpp_front, dpp_queue, dpp_back

module date_pattern_parser import dpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dpp_req_if.sink  req_ch,
   dpp_rsp_if.source rsp_ch
);

   // record of a finished pattern travels front -> queue -> back
   dpp_rec_type push_rec;
   dpp_rec_type head;
   logic        push;
   logic        pop;
   logic        q_full;
   logic        q_empty;

   // front: scans characters, splits fields at slashes, checks month and day
   // ranges as each field closes, pushes a record on the last character
   dpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push     (push),
      .push_rec (push_rec)
   );

   // short queue so a stalled response does not block the character stream
   dpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   // back: year checks, leap rule, day-in-month check, response register
   dpp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (head),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
